/* sv/ray_cone_triangle_lod_constant_defines.svh */
// ----------------------------------------------------------------------------
// Ray-cone LOD constant: assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RAY_CONE_TRIANGLE_LOD_CONSTANT_DEFINES_SVH
`define RAY_CONE_TRIANGLE_LOD_CONSTANT_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RCLC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rclc_pkg.sv */
// ----------------------------------------------------------------------------
// Ray-cone LOD constant package
// Types and fixed constants shared by the sequencer, MAC unit and log2 unit.
// ----------------------------------------------------------------------------
package rclc_pkg;

    localparam int LOG_F      = 24;
    localparam int MANT_W     = 31;
    localparam int SQ_W       = 2 * MANT_W;
    localparam int OUT_W      = 16;
    localparam int LOG_SCALE  = LOG_F + 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_LOAD,
        ST_MUL,
        ST_NEXT,
        ST_ABS,
        ST_ZCHK,
        ST_NORM,
        ST_LOG,
        ST_LWAIT,
        ST_FIN,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_UV_P,
        OP_UV_M,
        OP_CX_P,
        OP_CX_M,
        OP_CY_P,
        OP_CY_M,
        OP_CZ_P,
        OP_CZ_M,
        OP_SX,
        OP_SY,
        OP_SZ
    } t_op;

    typedef enum logic [2:0] {
        MAC_NONE,
        MAC_CLEAR,
        MAC_LOAD,
        MAC_STEP,
        MAC_NEG,
        MAC_SHL
    } t_mac_op;

    typedef struct packed {
        t_mac_op op;
        logic    sub;
    } t_mac_ctl;

endpackage

/* sv/rclc_mac.sv */
// ----------------------------------------------------------------------------
// Ray-cone LOD constant: shared multiply-accumulate unit
// Shift-add multiplier, one multiplier bit per cycle, into a wide accumulator
// that also negates and shifts left for normalization.
// ----------------------------------------------------------------------------
module rclc_mac #(
    parameter int MW    = 67,
    parameter int ACC_W = 136
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rclc_pkg::t_mac_ctl      i_ctl,
    input  logic signed [MW-1:0]    i_a,
    input  logic signed [MW-1:0]    i_b,
    output logic [ACC_W-1:0]        o_acc
);

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_mcand;
    logic [MW-1:0]    r_mplier;
    logic [ACC_W-1:0] a_ext;
    logic [MW-1:0]    b_mag;
    logic             neg;

    assign a_ext = {{(ACC_W - MW){i_a[MW-1]}}, i_a};
    assign b_mag = i_b[MW-1] ? MW'(-i_b) : i_b;
    assign neg   = i_b[MW-1] ^ i_ctl.sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_mcand  <= '0;
            r_mplier <= '0;
        end else begin
            case (i_ctl.op)
                rclc_pkg::MAC_CLEAR: begin
                    r_acc <= '0;
                end
                rclc_pkg::MAC_LOAD: begin
                    r_mcand  <= neg ? (~a_ext + ACC_W'(1)) : a_ext;
                    r_mplier <= b_mag;
                end
                rclc_pkg::MAC_STEP: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= {r_mcand[ACC_W-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[MW-1:1]};
                end
                rclc_pkg::MAC_NEG: begin
                    r_acc <= ~r_acc + ACC_W'(1);
                end
                rclc_pkg::MAC_SHL: begin
                    r_acc <= {r_acc[ACC_W-2:0], 1'b0};
                end
                default: begin
                end
            endcase
        end
    end

    assign o_acc = r_acc;

endmodule

/* sv/rclc_log.sv */
// ----------------------------------------------------------------------------
// Ray-cone LOD constant: log2 fraction unit
// Repeated squaring of a Q1.30 mantissa, one fraction bit per squaring step.
// ----------------------------------------------------------------------------
module rclc_log #(
    parameter int EXP_W = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [rclc_pkg::MANT_W-1:0]           i_mant,
    input  logic [EXP_W-1:0]                      i_exp,
    output logic                                  o_busy,
    output logic [EXP_W+rclc_pkg::LOG_F-1:0]      o_log
);

    localparam int CNT_W = $clog2(rclc_pkg::LOG_F);

    logic                          r_busy;
    logic                          r_phase;
    logic [CNT_W-1:0]              r_cnt;
    logic [rclc_pkg::MANT_W-1:0]   r_m;
    logic [rclc_pkg::SQ_W-1:0]     r_sq;
    logic [rclc_pkg::LOG_F-1:0]    r_frac;
    logic [EXP_W-1:0]              r_exp;
    logic [rclc_pkg::MANT_W:0]     t;

    assign t = r_sq[rclc_pkg::SQ_W-1 -: (rclc_pkg::MANT_W + 1)];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
            r_cnt   <= '0;
            r_m     <= i_mant;
            r_exp   <= i_exp;
            r_frac  <= '0;
        end else if (r_busy) begin
            r_phase <= ~r_phase;
            if (!r_phase) begin
                r_sq <= r_m * r_m;
            end else begin
                r_m    <= t[rclc_pkg::MANT_W] ? t[rclc_pkg::MANT_W:1]
                                              : t[rclc_pkg::MANT_W-1:0];
                r_frac <= {r_frac[rclc_pkg::LOG_F-2:0], t[rclc_pkg::MANT_W]};
                r_cnt  <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(rclc_pkg::LOG_F - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_log  = {r_exp, r_frac};

endmodule

/* sv/ray_cone_triangle_lod_constant.sv */
// ----------------------------------------------------------------------------
// Ray-cone triangle LOD constant
// Per-triangle LOD constant 0.5*log2(UV area / world area), signed Q6.10.
// ----------------------------------------------------------------------------
// Vertices arrive one per transfer; slots 0 and 1 are only stored, slot 3 is
// dropped, slot 2 starts the triangle computation. All area products run
// through one shift-add multiplier, one multiplier bit per cycle: eleven
// products of MW = 2*POS_WIDTH+3 multiplier bits each, plus a normalizing
// shift of one bit at a time and a log2 in the squaring unit for each of the
// two areas. The input stalls from the slot 2 transfer until the result
// enters the output register. A finished result sits in the output register
// while the next vertices are taken.
// ----------------------------------------------------------------------------
`include "ray_cone_triangle_lod_constant_defines.svh"

module ray_cone_triangle_lod_constant #(
    parameter int UV_WIDTH      = 24,
    parameter int POS_WIDTH     = 32,
    parameter int LOD_FRAC_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [UV_WIDTH-1:0]    i_vertex_u,
    input  logic signed [UV_WIDTH-1:0]    i_vertex_v,
    input  logic signed [POS_WIDTH-1:0]   i_vertex_x,
    input  logic signed [POS_WIDTH-1:0]   i_vertex_y,
    input  logic signed [POS_WIDTH-1:0]   i_vertex_z,
    input  logic [1:0]                    i_vertex_slot,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [rclc_pkg::OUT_W-1:0] o_lod_constant,
    output logic                          o_is_degenerate,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic signed [rclc_pkg::OUT_W-1:0] i_cfg_data
);

    localparam int DW     = POS_WIDTH + 1;
    localparam int MW     = 2 * DW + 1;
    localparam int ACC_W  = 2 * MW + 2;
    localparam int CNT_W  = $clog2(MW);
    localparam int EXP_W  = $clog2(ACC_W);
    localparam int LOG_W  = EXP_W + rclc_pkg::LOG_F;
    localparam int NUM_W  = LOG_W + 2;
    localparam int SH     = rclc_pkg::LOG_SCALE - LOD_FRAC_BITS;
    localparam logic signed [NUM_W-1:0] RND   = NUM_W'(1) << (SH - 1);
    localparam logic signed [NUM_W-1:0] Q_MAX = NUM_W'(32767);
    localparam logic signed [NUM_W-1:0] Q_MIN = -Q_MAX - NUM_W'(1);

    rclc_pkg::t_state r_state, n_state;
    rclc_pkg::t_op    r_op;
    rclc_pkg::t_mac_ctl mac_ctl;
    logic             log_start;

    logic signed [UV_WIDTH-1:0]  r_u0, r_v0, r_u1, r_v1, r_u2, r_v2;
    logic signed [POS_WIDTH-1:0] r_x0, r_y0, r_z0, r_x1, r_y1, r_z1, r_x2, r_y2, r_z2;
    logic signed [MW-1:0]        r_cx, r_cy, r_cz;
    logic [CNT_W-1:0]            r_cnt;
    logic [EXP_W-1:0]            r_shift;
    logic [LOG_W-1:0]            r_lc, r_ls;
    logic signed [rclc_pkg::OUT_W-1:0] r_degen_lod;
    logic signed [rclc_pkg::OUT_W-1:0] r_out_lod;
    logic                        r_out_degen, r_out_valid, r_degen;

    logic [ACC_W-1:0]            acc;
    logic                        log_busy;
    logic [LOG_W-1:0]            log_val;
    logic signed [MW-1:0]        opa, opb;
    logic signed [UV_WIDTH:0]    du1, dv1, du2, dv2;
    logic signed [DW-1:0]        a1x, a1y, a1z, a2x, a2y, a2z;
    logic signed [NUM_W-1:0]     num, q;
    logic signed [rclc_pkg::OUT_W-1:0] lod_sat;
    logic                        in_acc, out_free, acc_zero;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign acc_zero = (acc == '0);

    assign du1 = $signed({r_u1[UV_WIDTH-1], r_u1}) - $signed({r_u0[UV_WIDTH-1], r_u0});
    assign dv1 = $signed({r_v1[UV_WIDTH-1], r_v1}) - $signed({r_v0[UV_WIDTH-1], r_v0});
    assign du2 = $signed({r_u2[UV_WIDTH-1], r_u2}) - $signed({r_u0[UV_WIDTH-1], r_u0});
    assign dv2 = $signed({r_v2[UV_WIDTH-1], r_v2}) - $signed({r_v0[UV_WIDTH-1], r_v0});
    assign a1x = $signed({r_x1[POS_WIDTH-1], r_x1}) - $signed({r_x0[POS_WIDTH-1], r_x0});
    assign a1y = $signed({r_y1[POS_WIDTH-1], r_y1}) - $signed({r_y0[POS_WIDTH-1], r_y0});
    assign a1z = $signed({r_z1[POS_WIDTH-1], r_z1}) - $signed({r_z0[POS_WIDTH-1], r_z0});
    assign a2x = $signed({r_x2[POS_WIDTH-1], r_x2}) - $signed({r_x0[POS_WIDTH-1], r_x0});
    assign a2y = $signed({r_y2[POS_WIDTH-1], r_y2}) - $signed({r_y0[POS_WIDTH-1], r_y0});
    assign a2z = $signed({r_z2[POS_WIDTH-1], r_z2}) - $signed({r_z0[POS_WIDTH-1], r_z0});

    always_comb begin
        opa = '0;
        opb = '0;
        case (r_op)
            rclc_pkg::OP_UV_P: begin
                opa = {{(MW-UV_WIDTH-1){du1[UV_WIDTH]}}, du1};
                opb = {{(MW-UV_WIDTH-1){dv2[UV_WIDTH]}}, dv2};
            end
            rclc_pkg::OP_UV_M: begin
                opa = {{(MW-UV_WIDTH-1){dv1[UV_WIDTH]}}, dv1};
                opb = {{(MW-UV_WIDTH-1){du2[UV_WIDTH]}}, du2};
            end
            rclc_pkg::OP_CX_P: begin
                opa = {{(MW-DW){a1y[DW-1]}}, a1y};
                opb = {{(MW-DW){a2z[DW-1]}}, a2z};
            end
            rclc_pkg::OP_CX_M: begin
                opa = {{(MW-DW){a1z[DW-1]}}, a1z};
                opb = {{(MW-DW){a2y[DW-1]}}, a2y};
            end
            rclc_pkg::OP_CY_P: begin
                opa = {{(MW-DW){a1z[DW-1]}}, a1z};
                opb = {{(MW-DW){a2x[DW-1]}}, a2x};
            end
            rclc_pkg::OP_CY_M: begin
                opa = {{(MW-DW){a1x[DW-1]}}, a1x};
                opb = {{(MW-DW){a2z[DW-1]}}, a2z};
            end
            rclc_pkg::OP_CZ_P: begin
                opa = {{(MW-DW){a1x[DW-1]}}, a1x};
                opb = {{(MW-DW){a2y[DW-1]}}, a2y};
            end
            rclc_pkg::OP_CZ_M: begin
                opa = {{(MW-DW){a1y[DW-1]}}, a1y};
                opb = {{(MW-DW){a2x[DW-1]}}, a2x};
            end
            rclc_pkg::OP_SX: begin
                opa = r_cx;
                opb = r_cx;
            end
            rclc_pkg::OP_SY: begin
                opa = r_cy;
                opb = r_cy;
            end
            rclc_pkg::OP_SZ: begin
                opa = r_cz;
                opb = r_cz;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rclc_pkg::ST_IDLE: begin
                if (in_acc && i_vertex_slot == 2'd2) begin
                    n_state = rclc_pkg::ST_CLR;
                end
            end
            rclc_pkg::ST_CLR:  n_state = rclc_pkg::ST_LOAD;
            rclc_pkg::ST_LOAD: n_state = rclc_pkg::ST_MUL;
            rclc_pkg::ST_MUL: begin
                if (r_cnt == CNT_W'(MW - 1)) begin
                    n_state = rclc_pkg::ST_NEXT;
                end
            end
            rclc_pkg::ST_NEXT: begin
                case (r_op)
                    rclc_pkg::OP_UV_M: n_state = rclc_pkg::ST_ABS;
                    rclc_pkg::OP_CX_M,
                    rclc_pkg::OP_CY_M,
                    rclc_pkg::OP_CZ_M: n_state = rclc_pkg::ST_CLR;
                    rclc_pkg::OP_SZ:   n_state = rclc_pkg::ST_ZCHK;
                    default:           n_state = rclc_pkg::ST_LOAD;
                endcase
            end
            rclc_pkg::ST_ABS:  n_state = rclc_pkg::ST_ZCHK;
            rclc_pkg::ST_ZCHK: n_state = acc_zero ? rclc_pkg::ST_DONE : rclc_pkg::ST_NORM;
            rclc_pkg::ST_NORM: begin
                if (acc[ACC_W-1]) begin
                    n_state = rclc_pkg::ST_LOG;
                end
            end
            rclc_pkg::ST_LOG:  n_state = rclc_pkg::ST_LWAIT;
            rclc_pkg::ST_LWAIT: begin
                if (!log_busy) begin
                    n_state = (r_op == rclc_pkg::OP_UV_M) ? rclc_pkg::ST_CLR
                                                          : rclc_pkg::ST_FIN;
                end
            end
            rclc_pkg::ST_FIN:  n_state = rclc_pkg::ST_DONE;
            rclc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = rclc_pkg::ST_IDLE;
                end
            end
            default: n_state = rclc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mac_ctl.op  = rclc_pkg::MAC_NONE;
        mac_ctl.sub = (r_op == rclc_pkg::OP_UV_M) || (r_op == rclc_pkg::OP_CX_M) ||
                      (r_op == rclc_pkg::OP_CY_M) || (r_op == rclc_pkg::OP_CZ_M);
        log_start   = 1'b0;
        case (r_state)
            rclc_pkg::ST_CLR:  mac_ctl.op = rclc_pkg::MAC_CLEAR;
            rclc_pkg::ST_LOAD: mac_ctl.op = rclc_pkg::MAC_LOAD;
            rclc_pkg::ST_MUL:  mac_ctl.op = rclc_pkg::MAC_STEP;
            rclc_pkg::ST_ABS: begin
                if (acc[ACC_W-1]) begin
                    mac_ctl.op = rclc_pkg::MAC_NEG;
                end
            end
            rclc_pkg::ST_NORM: begin
                if (!acc[ACC_W-1]) begin
                    mac_ctl.op = rclc_pkg::MAC_SHL;
                end
            end
            rclc_pkg::ST_LOG:  log_start = 1'b1;
            default: begin
            end
        endcase
    end

    assign num = $signed({1'b0, r_lc, 1'b0}) - $signed({2'b00, r_ls}) + RND;
    assign q   = num >>> SH;
    always_comb begin
        if (q > Q_MAX) begin
            lod_sat = Q_MAX[rclc_pkg::OUT_W-1:0];
        end else if (q < Q_MIN) begin
            lod_sat = Q_MIN[rclc_pkg::OUT_W-1:0];
        end else begin
            lod_sat = q[rclc_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rclc_pkg::ST_IDLE;
            r_op        <= rclc_pkg::OP_UV_P;
            r_cnt       <= '0;
            r_shift     <= '0;
            r_degen     <= 1'b0;
            r_out_valid <= 1'b0;
            r_degen_lod <= rclc_pkg::OUT_W'(16'h8000);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_degen_lod <= i_cfg_data;
            end
            if (in_acc) begin
                case (i_vertex_slot)
                    2'd0: begin
                        r_u0 <= i_vertex_u;
                        r_v0 <= i_vertex_v;
                        r_x0 <= i_vertex_x;
                        r_y0 <= i_vertex_y;
                        r_z0 <= i_vertex_z;
                    end
                    2'd1: begin
                        r_u1 <= i_vertex_u;
                        r_v1 <= i_vertex_v;
                        r_x1 <= i_vertex_x;
                        r_y1 <= i_vertex_y;
                        r_z1 <= i_vertex_z;
                    end
                    2'd2: begin
                        r_u2  <= i_vertex_u;
                        r_v2  <= i_vertex_v;
                        r_x2  <= i_vertex_x;
                        r_y2  <= i_vertex_y;
                        r_z2  <= i_vertex_z;
                        r_op  <= rclc_pkg::OP_UV_P;
                        r_degen <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            case (r_state)
                rclc_pkg::ST_LOAD: r_cnt <= '0;
                rclc_pkg::ST_MUL:  r_cnt <= r_cnt + CNT_W'(1);
                rclc_pkg::ST_NEXT: begin
                    case (r_op)
                        rclc_pkg::OP_CX_M: r_cx <= acc[MW-1:0];
                        rclc_pkg::OP_CY_M: r_cy <= acc[MW-1:0];
                        rclc_pkg::OP_CZ_M: r_cz <= acc[MW-1:0];
                        default: begin
                        end
                    endcase
                    if (r_op != rclc_pkg::OP_UV_M && r_op != rclc_pkg::OP_SZ) begin
                        r_op <= rclc_pkg::t_op'(r_op + 4'd1);
                    end
                end
                rclc_pkg::ST_ZCHK: begin
                    r_shift <= '0;
                    r_degen <= acc_zero;
                end
                rclc_pkg::ST_NORM: begin
                    if (!acc[ACC_W-1]) begin
                        r_shift <= r_shift + EXP_W'(1);
                    end
                end
                rclc_pkg::ST_LWAIT: begin
                    if (!log_busy) begin
                        if (r_op == rclc_pkg::OP_UV_M) begin
                            r_lc <= log_val;
                            r_op <= rclc_pkg::OP_CX_P;
                        end else begin
                            r_ls <= log_val;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (r_state == rclc_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out_degen <= r_degen;
                r_out_lod   <= r_degen ? r_degen_lod : lod_sat;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    rclc_mac #(
        .MW    (MW),
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (opa),
        .i_b     (opb),
        .o_acc   (acc)
    );

    rclc_log #(
        .EXP_W (EXP_W)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_mant  (acc[ACC_W-1 -: rclc_pkg::MANT_W]),
        .i_exp   (EXP_W'(ACC_W - 1) - r_shift),
        .o_busy  (log_busy),
        .o_log   (log_val)
    );

    assign o_in_stall      = (r_state != rclc_pkg::ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_lod_constant  = r_out_lod;
    assign o_is_degenerate = r_out_degen;
    assign o_cfg_ready     = 1'b1;

    `RCLC_ASSERT_NEXT(a_slot2_starts, in_acc && i_vertex_slot == 2'd2, r_state == rclc_pkg::ST_CLR, "slot 2 transfer did not start the sequence")
    `RCLC_ASSERT_NOW(a_norm_nonzero, r_state == rclc_pkg::ST_NORM, !acc_zero, "normalizing a zero accumulator")
    `RCLC_ASSERT_NEXT(a_uv_log_to_world, r_state == rclc_pkg::ST_LWAIT && !log_busy && r_op == rclc_pkg::OP_UV_M, r_state == rclc_pkg::ST_CLR && r_op == rclc_pkg::OP_CX_P, "world area pass did not follow UV log")
    `RCLC_ASSERT_NOW(a_log_busy_wait, r_state == rclc_pkg::ST_LOG, !log_busy, "log unit restarted while busy")

endmodule
